@@ src/gtid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtid_pkg
// Shared types and codes of the grouped thread id allocator.
// ----------------------------------------------------------------------------
package gtid_pkg;

   localparam int TASK_SLOTS_DEF       = 16;
   localparam int THREADS_PER_TASK_DEF = 128;

   localparam logic [1:0] OP_ALLOC    = 2'd0;
   localparam logic [1:0] OP_FREE     = 2'd1;
   localparam logic [1:0] OP_CLASSIFY = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SLOT   = 2'd1;
   localparam logic [1:0] ST_TASK_FULL = 2'd2;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [10:0] task_number;
      logic [6:0]  thread_number;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] granted_thread;
      logic       whole_space;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic match;
      logic lookup;
      logic load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic table_op;
   } stat_type;

endpackage

@@ src/gtid_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtid_ctrl
// Sequencer: compare, lookup, load, finish; unused opcode skips lookup, load.
// ----------------------------------------------------------------------------
module gtid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gtid_pkg::stat_type stat,
   output gtid_pkg::cmd_type  cmd
);
   import gtid_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MATCH  = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = stat.table_op ? S_LOOKUP : S_FINISH;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ src/gtid_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtid_datapath
// Slot tag table, per-slot thread bitmap memory, lowest-clear search and
// response register.
// ----------------------------------------------------------------------------
module gtid_datapath #(
   parameter int TASK_SLOTS       = gtid_pkg::TASK_SLOTS_DEF,
   parameter int THREADS_PER_TASK = gtid_pkg::THREADS_PER_TASK_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gtid_pkg::cmd_type      cmd,
   output gtid_pkg::stat_type     stat,
   input  gtid_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output gtid_pkg::rsp_word_type rsp_word
);
   import gtid_pkg::*;

   localparam int SLOT_W   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int THREAD_W = $clog2(THREADS_PER_TASK);
   localparam int GROUPS   = (THREADS_PER_TASK + 15) / 16;
   localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int IDX_W    = GRP_W + 4;

   req_word_type                req_ff;
   logic [10:0]                 tag_ff [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]       match_ff;
   logic [TASK_SLOTS-1:0]       free_ff;
   logic [SLOT_W-1:0]           slot_ff;
   logic                        have_ff;
   logic                        claim_ff;
   logic [THREADS_PER_TASK-1:0] mem [TASK_SLOTS];
   logic [THREADS_PER_TASK-1:0] rdata_ff;
   logic [THREADS_PER_TASK-1:0] word_ff;
   logic [GROUPS-1:0]           grpz_ff;
   logic                        bit_ok_ff;
   logic                        rsp_strobe_ff;
   rsp_word_type                rsp_ff;

   logic                        hit;
   logic [SLOT_W-1:0]           hit_idx;
   logic                        free_any;
   logic [SLOT_W-1:0]           free_idx;
   logic                        claim_in;
   logic                        have_in;
   logic [SLOT_W-1:0]           slot_in;
   logic [THREADS_PER_TASK-1:0] word_in;
   logic [GROUPS*16-1:0]        pad_in;
   logic [GROUPS-1:0]           grpz_in;
   logic                        in_range;
   logic [THREAD_W-1:0]         thr_idx;
   logic [GROUPS*16-1:0]        pad_fin;
   logic [GRP_W-1:0]            grp_sel;
   logic [15:0]                 chunk;
   logic [3:0]                  lo_sel;
   logic [IDX_W-1:0]            grant_full;
   logic [THREAD_W-1:0]         grant;
   logic                        found;
   logic [THREADS_PER_TASK-1:0] set_word;
   logic [THREADS_PER_TASK-1:0] clr_word;
   logic                        mem_we;
   logic [THREADS_PER_TASK-1:0] mem_wdata;
   logic                        tag_release;
   rsp_word_type                rsp_in;

   assign stat.table_op = (req_ff.opcode != OP_UNUSED);
   assign thr_idx       = req_ff.thread_number[THREAD_W-1:0];
   assign in_range      = ({1'b0, req_ff.thread_number} < 8'(THREADS_PER_TASK));

   // slot lookup
   always_comb begin
      hit      = |match_ff;
      free_any = |free_ff;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (free_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
      claim_in = (req_ff.opcode == OP_ALLOC) && !hit && (req_ff.task_number != 11'd0)
                 && free_any;
      have_in  = hit || claim_in;
      slot_in  = hit ? hit_idx : free_idx;
   end

   // bitmap load and group flags
   always_comb begin
      if (claim_ff) begin
         word_in = THREADS_PER_TASK'(1);
      end else if (have_ff) begin
         word_in = rdata_ff;
      end else begin
         word_in = '0;
      end
      pad_in                         = '1;
      pad_in[THREADS_PER_TASK-1:0]   = word_in;
      for (int g = 0; g < GROUPS; g++) begin
         grpz_in[g] = ~&pad_in[g*16 +: 16];
      end
   end

   // lowest clear thread and update words
   always_comb begin
      pad_fin                       = '1;
      pad_fin[THREADS_PER_TASK-1:0] = word_ff;
      grp_sel = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grpz_ff[g]) begin
            grp_sel = GRP_W'(g);
         end
      end
      chunk  = pad_fin[grp_sel*16 +: 16];
      lo_sel = '0;
      for (int b = 15; b >= 0; b--) begin
         if (!chunk[b]) begin
            lo_sel = 4'(b);
         end
      end
      found      = |grpz_ff;
      grant_full = {grp_sel, lo_sel};
      grant      = grant_full[THREAD_W-1:0];
      set_word   = word_ff;
      if (found) begin
         set_word[grant] = 1'b1;
      end
      clr_word          = word_ff;
      clr_word[thr_idx] = 1'b0;
   end

   // response and writes
   always_comb begin
      rsp_in      = '0;
      mem_we      = 1'b0;
      mem_wdata   = set_word;
      tag_release = 1'b0;
      case (req_ff.opcode)
         OP_ALLOC: begin
            if (!have_ff) begin
               rsp_in.status = ST_NO_SLOT;
            end else begin
               mem_we = cmd.finish;
               if (found) begin
                  rsp_in.status         = ST_OK;
                  rsp_in.granted_thread = 7'(grant);
               end else begin
                  rsp_in.status = ST_TASK_FULL;
               end
            end
         end
         OP_FREE: begin
            if (!have_ff) begin
               rsp_in.whole_space = 1'b1;
            end else if (!bit_ok_ff) begin
               rsp_in.status = ST_NOT_ALLOC;
            end else begin
               mem_we    = cmd.finish;
               mem_wdata = clr_word;
               if (~|clr_word) begin
                  tag_release        = cmd.finish;
                  rsp_in.whole_space = 1'b1;
               end
            end
         end
         OP_CLASSIFY: begin
            rsp_in.whole_space = !have_ff || (~|word_ff) || (req_ff.thread_number == 7'd0);
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (cmd.match) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            match_ff[i] <= (tag_ff[i] == req_ff.task_number) && (req_ff.task_number != 11'd0);
            free_ff[i]  <= (tag_ff[i] == 11'd0);
         end
         have_ff  <= 1'b0;
         claim_ff <= 1'b0;
      end
      if (cmd.lookup) begin
         slot_ff  <= slot_in;
         have_ff  <= have_in;
         claim_ff <= claim_in;
         rdata_ff <= mem[slot_in];
      end
      if (cmd.load) begin
         word_ff   <= word_in;
         grpz_ff   <= grpz_in;
         bit_ok_ff <= in_range && word_in[thr_idx];
      end
      if (mem_we) begin
         mem[slot_ff] <= mem_wdata;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            tag_ff[i] <= '0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
         if (cmd.lookup && claim_in) begin
            tag_ff[slot_in] <= req_ff.task_number;
         end
         if (tag_release) begin
            tag_ff[slot_ff] <= '0;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

@@ src/grouped_thread_id_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_thread_id_allocator
// Per-task thread number allocator over a table of task slots.
// ----------------------------------------------------------------------------
// A request word is taken when start is high while busy is low. Its response
// word appears on rsp_word with rsp_strobe high for exactly one cycle, once the
// request has gone through parallel tag compare, slot encode with bitmap memory
// read, bitmap load with group flags, lowest-clear search with write-back, then
// the response register; the unused opcode skips slot encode and bitmap load.
// The response word is registered; it cannot be held off, so capture it on the
// strobe. busy drops in the strobe cycle, so a new request is taken only after
// the last one has completed.
// ----------------------------------------------------------------------------
module grouped_thread_id_allocator #(
   parameter int TASK_SLOTS       = gtid_pkg::TASK_SLOTS_DEF,
   parameter int THREADS_PER_TASK = gtid_pkg::THREADS_PER_TASK_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gtid_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output gtid_pkg::rsp_word_type rsp_word
);
   import gtid_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   gtid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   gtid_datapath #(
      .TASK_SLOTS       (TASK_SLOTS),
      .THREADS_PER_TASK (THREADS_PER_TASK)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
